// ===== hdl/spss_pkg.sv =====
// ----------------------------------------------------------------------------
// spss_pkg
// Shared types, constants and pattern tables of the servo pattern slew
// sequencer.
// ----------------------------------------------------------------------------
package spss_pkg;

	localparam int SPSS_POS_FRAC_BITS = 10;
	localparam int TIME_FRAC_BITS     = 20;

	localparam int PCT_W     = 7;
	localparam int SPEED_W   = 10;
	localparam int ELAPSED_W = 16;
	localparam int SEL_W     = 3;
	localparam int STEP_W    = 3;
	localparam int PULSE_W   = 12;
	localparam int TENTHS_W  = 10;
	localparam int PROD_W    = SPEED_W + ELAPSED_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam int PCT_MAX      = 100;
	localparam int MID_OFFSET   = 20;
	localparam int MID_FALLBACK = 80;
	localparam int TENTHS_MAX   = 1000;
	localparam int PULSE_MIN_US = 500;
	localparam int PULSE_MAX_US = 2500;
	localparam int RESET_TARGET_PCT = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLEW_SPEED = 3'd0,
		CFG_ONE_SHOT   = 3'd1,
		CFG_POS_ZERO   = 3'd2,
		CFG_POS_LOW    = 3'd3,
		CFG_POS_MID    = 3'd4,
		CFG_POS_HIGH   = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		TGT_ZERO    = 3'd0,
		TGT_LOW     = 3'd1,
		TGT_MID     = 3'd2,
		TGT_HIGH    = 3'd3,
		TGT_MID_M20 = 3'd4
	} tgt_code_t;

	typedef struct packed {
		logic [SPEED_W-1:0] slew_speed;
		logic               one_shot;
		logic [PCT_W-1:0]   pos_zero;
		logic [PCT_W-1:0]   pos_low;
		logic [PCT_W-1:0]   pos_mid;
		logic [PCT_W-1:0]   pos_high;
	} cfg_t;

	typedef struct packed {
		logic [SEL_W-1:0]  pattern;
		logic [STEP_W-1:0] step;
		logic              load;
	} seq_upd_t;

	localparam logic [2:0] STEP_COUNT [8] = '{3'd0, 3'd4, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0, 3'd4};

	localparam tgt_code_t TGT_LEFT [8][4] = '{
		'{TGT_ZERO, TGT_ZERO,    TGT_ZERO, TGT_ZERO},
		'{TGT_LOW,  TGT_MID,     TGT_LOW,  TGT_LOW},
		'{TGT_LOW,  TGT_MID,     TGT_ZERO, TGT_ZERO},
		'{TGT_MID,  TGT_MID_M20, TGT_ZERO, TGT_ZERO},
		'{TGT_LOW,  TGT_MID,     TGT_ZERO, TGT_ZERO},
		'{TGT_MID,  TGT_MID,     TGT_MID,  TGT_MID},
		'{TGT_HIGH, TGT_HIGH,    TGT_HIGH, TGT_HIGH},
		'{TGT_LOW,  TGT_LOW,     TGT_HIGH, TGT_MID}
	};

	localparam tgt_code_t TGT_RIGHT [8][4] = '{
		'{TGT_ZERO,    TGT_ZERO, TGT_ZERO, TGT_ZERO},
		'{TGT_LOW,     TGT_LOW,  TGT_LOW,  TGT_MID},
		'{TGT_MID,     TGT_LOW,  TGT_ZERO, TGT_ZERO},
		'{TGT_MID_M20, TGT_MID,  TGT_ZERO, TGT_ZERO},
		'{TGT_LOW,     TGT_MID,  TGT_ZERO, TGT_ZERO},
		'{TGT_MID,     TGT_MID,  TGT_MID,  TGT_MID},
		'{TGT_HIGH,    TGT_HIGH, TGT_HIGH, TGT_HIGH},
		'{TGT_LOW,     TGT_MID,  TGT_HIGH, TGT_LOW}
	};

endpackage

// ===== hdl/spss_if.sv =====
// ----------------------------------------------------------------------------
// spss_if
// Handshake channels of the servo pattern slew sequencer: command words in,
// pulse report words out.
// ----------------------------------------------------------------------------
interface spss_in_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic [spss_pkg::ELAPSED_W-1:0]    elapsed;
	logic [spss_pkg::SEL_W-1:0]        pattern_sel;

	modport source (output valid, kind, elapsed, pattern_sel, input ready);
	modport sink (input valid, kind, elapsed, pattern_sel, output ready);
endinterface

interface spss_out_if;
	logic                           valid;
	logic                           ready;
	logic [spss_pkg::PULSE_W-1:0]   left_pulse_us;
	logic [spss_pkg::PULSE_W-1:0]   right_pulse_us;
	logic [spss_pkg::SEL_W-1:0]     active_pattern;
	logic [spss_pkg::STEP_W-1:0]    active_step;
	logic                           at_target;

	modport source (output valid, left_pulse_us, right_pulse_us, active_pattern,
		active_step, at_target, input ready);
	modport sink (input valid, left_pulse_us, right_pulse_us, active_pattern,
		active_step, at_target, output ready);
endinterface

// ===== hdl/spss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// spss_cfg_regs
// Configuration register file: slew speed, one-shot mode and the four
// pattern positions.
// ----------------------------------------------------------------------------
module spss_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [spss_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [spss_pkg::CFG_DATA_W-1:0]     cfg_data,
	output spss_pkg::cfg_t                      cfg
);

	spss_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slew_speed <= spss_pkg::SPEED_W'(35);
			cfg_q.one_shot   <= 1'b0;
			cfg_q.pos_zero   <= spss_pkg::PCT_W'(0);
			cfg_q.pos_low    <= spss_pkg::PCT_W'(20);
			cfg_q.pos_mid    <= spss_pkg::PCT_W'(55);
			cfg_q.pos_high   <= spss_pkg::PCT_W'(70);
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				spss_pkg::CFG_SLEW_SPEED: cfg_q.slew_speed <= cfg_data[spss_pkg::SPEED_W-1:0];
				spss_pkg::CFG_ONE_SHOT:   cfg_q.one_shot   <= cfg_data[0];
				spss_pkg::CFG_POS_ZERO:   cfg_q.pos_zero   <= cfg_data[spss_pkg::PCT_W-1:0];
				spss_pkg::CFG_POS_LOW:    cfg_q.pos_low    <= cfg_data[spss_pkg::PCT_W-1:0];
				spss_pkg::CFG_POS_MID:    cfg_q.pos_mid    <= cfg_data[spss_pkg::PCT_W-1:0];
				spss_pkg::CFG_POS_HIGH:   cfg_q.pos_high   <= cfg_data[spss_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/spss_step_ctrl.sv =====
// ----------------------------------------------------------------------------
// spss_step_ctrl
// Pattern step sequencing: takes a new pattern on a select command, advances
// the step, handles pattern end and looks up the target pair of the step.
// ----------------------------------------------------------------------------
module spss_step_ctrl #(
	parameter int POS_FRAC_BITS = spss_pkg::SPSS_POS_FRAC_BITS
) (
	input  logic                               kind,
	input  logic [spss_pkg::SEL_W-1:0]         pattern_sel,
	input  spss_pkg::cfg_t                     cfg,
	input  logic [spss_pkg::SEL_W-1:0]         pattern,
	input  logic [spss_pkg::STEP_W-1:0]        step,
	input  logic                               finished,
	output spss_pkg::seq_upd_t                 upd,
	output logic [spss_pkg::PCT_W+POS_FRAC_BITS-1:0] left_tgt,
	output logic [spss_pkg::PCT_W+POS_FRAC_BITS-1:0] right_tgt
);

	localparam int POS_W = spss_pkg::PCT_W + POS_FRAC_BITS;

	function automatic logic [POS_W-1:0] code_to_fixed(input spss_pkg::tgt_code_t code,
		input spss_pkg::cfg_t c);
		logic [spss_pkg::PCT_W-1:0] p;
		case (code)
			spss_pkg::TGT_ZERO: p = c.pos_zero;
			spss_pkg::TGT_LOW:  p = c.pos_low;
			spss_pkg::TGT_MID:  p = c.pos_mid;
			spss_pkg::TGT_HIGH: p = c.pos_high;
			spss_pkg::TGT_MID_M20: begin
				if (c.pos_mid > spss_pkg::PCT_W'(spss_pkg::PCT_MAX))
					p = spss_pkg::PCT_W'(spss_pkg::MID_FALLBACK);
				else if (c.pos_mid >= spss_pkg::PCT_W'(spss_pkg::MID_OFFSET))
					p = c.pos_mid - spss_pkg::PCT_W'(spss_pkg::MID_OFFSET);
				else
					p = '0;
			end
			default: p = '0;
		endcase
		if (p > spss_pkg::PCT_W'(spss_pkg::PCT_MAX))
			p = spss_pkg::PCT_W'(spss_pkg::PCT_MAX);
		return POS_W'(p) << POS_FRAC_BITS;
	endfunction

	logic [spss_pkg::STEP_W-1:0] step_adv;
	logic [2:0]                  n_steps;
	logic [1:0]                  load_step;

	always_comb begin
		step_adv    = finished ? step + spss_pkg::STEP_W'(1) : step;
		n_steps     = spss_pkg::STEP_COUNT[pattern];
		upd.pattern = pattern;
		upd.step    = step_adv;
		upd.load    = 1'b1;
		load_step   = 2'd0;
		if (kind) begin
			upd.pattern = pattern_sel;
			upd.step    = '0;
			upd.load    = 1'b0;
		end else if (n_steps == 3'd0) begin
			load_step = 2'd0;
		end else if (step_adv < n_steps) begin
			load_step = step_adv[1:0];
		end else if (cfg.one_shot) begin
			upd.pattern = '0;
			upd.load    = 1'b0;
		end else begin
			upd.step = '0;
		end
	end

	assign left_tgt  = code_to_fixed(spss_pkg::TGT_LEFT[pattern][load_step], cfg);
	assign right_tgt = code_to_fixed(spss_pkg::TGT_RIGHT[pattern][load_step], cfg);

endmodule

// ===== hdl/spss_slew.sv =====
// ----------------------------------------------------------------------------
// spss_slew
// Moves one servo position toward its target by at most one slew step,
// without overshoot.
// ----------------------------------------------------------------------------
module spss_slew #(
	parameter int POS_W   = 17,
	parameter int DELTA_W = 16
) (
	input  logic [POS_W-1:0]   pos,
	input  logic [POS_W-1:0]   tgt,
	input  logic [DELTA_W-1:0] delta,
	output logic [POS_W-1:0]   pos_next
);

	logic [POS_W-1:0] delta_ext;
	logic [POS_W-1:0] diff;

	assign delta_ext = POS_W'(delta);

	always_comb begin
		diff = (tgt < pos) ? pos - tgt : tgt - pos;
		if (tgt < pos)
			pos_next = (diff <= delta_ext) ? tgt : pos - delta_ext;
		else if (tgt > pos)
			pos_next = (diff <= delta_ext) ? tgt : pos + delta_ext;
		else
			pos_next = pos;
	end

endmodule

// ===== hdl/servo_pattern_slew_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// servo_pattern_slew_sequencer_unit
// Two-servo pattern sequencer with slew limiting and pulse width output.
//
//   channel | dir | word
//   cmd     | in  | kind, elapsed, pattern_sel
//   res     | out | left_pulse_us, right_pulse_us, active_pattern, active_step,
//           |     | at_target
//   cfg     | in  | cfg_wr_en, cfg_idx, cfg_data
//
// Each command word gives one result word via the stage and result registers.
// The slew step product is registered with the command, then the step update,
// slew and pulse mapping are computed combinationally into the result register.
// One word is accepted per cycle while the result side takes its words.
// Reset zeroes both positions, pattern and step, sets both targets to 20
// percent and loads the configuration defaults. A stalled result holds the
// pipeline; the command input stalls only once both stages are full.
// ----------------------------------------------------------------------------
module servo_pattern_slew_sequencer_unit #(
	parameter int POS_FRAC_BITS = spss_pkg::SPSS_POS_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	spss_in_if.sink                             cmd,
	spss_out_if.source                          res,
	input  logic                                cfg_wr_en,
	input  logic [spss_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [spss_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int POS_W   = spss_pkg::PCT_W + POS_FRAC_BITS;
	localparam int SHIFT   = spss_pkg::TIME_FRAC_BITS - POS_FRAC_BITS;
	localparam int DELTA_W = spss_pkg::PROD_W - SHIFT;
	localparam int X10_W   = POS_W + 4;
	localparam int TRAW_W  = X10_W - POS_FRAC_BITS;

	spss_pkg::cfg_t     cfg;
	spss_pkg::seq_upd_t upd;

	logic                               valid_s1;
	logic                               kind_s1;
	logic [spss_pkg::SEL_W-1:0]         sel_s1;
	logic [DELTA_W-1:0]                 delta_s1;

	logic [POS_W-1:0]                   left_pos_q, right_pos_q;
	logic [POS_W-1:0]                   left_tgt_q, right_tgt_q;
	logic [spss_pkg::SEL_W-1:0]         pattern_q;
	logic [spss_pkg::STEP_W-1:0]        step_q;
	logic                               finished_q;

	logic                               res_valid_q;
	logic [spss_pkg::PULSE_W-1:0]       left_pulse_q, right_pulse_q;
	logic [spss_pkg::SEL_W-1:0]         res_pattern_q;
	logic [spss_pkg::STEP_W-1:0]        res_step_q;
	logic                               res_at_tgt_q;

	logic [spss_pkg::PROD_W-1:0]        prod;
	logic                               advance;
	logic                               cmd_acc;
	logic [POS_W-1:0]                   left_lut, right_lut;
	logic [POS_W-1:0]                   left_tgt_n, right_tgt_n;
	logic [POS_W-1:0]                   left_slew, right_slew;
	logic [POS_W-1:0]                   left_pos_n, right_pos_n;
	logic                               at_tgt_n;

	function automatic logic [spss_pkg::TENTHS_W-1:0] to_tenths(input logic [POS_W-1:0] p);
		logic [X10_W-1:0]  x10;
		logic [TRAW_W-1:0] t_raw;
		x10   = (X10_W'(p) << 3) + (X10_W'(p) << 1);
		t_raw = x10[X10_W-1:POS_FRAC_BITS];
		if (t_raw > TRAW_W'(spss_pkg::TENTHS_MAX))
			return spss_pkg::TENTHS_W'(spss_pkg::TENTHS_MAX);
		return t_raw[spss_pkg::TENTHS_W-1:0];
	endfunction

	spss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign prod      = spss_pkg::PROD_W'(cfg.slew_speed) * spss_pkg::PROD_W'(cmd.elapsed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			kind_s1  <= cmd.kind;
			sel_s1   <= cmd.pattern_sel;
			delta_s1 <= prod[spss_pkg::PROD_W-1:SHIFT];
		end
	end

	spss_step_ctrl #(
		.POS_FRAC_BITS (POS_FRAC_BITS)
	) u_step (
		.kind        (kind_s1),
		.pattern_sel (sel_s1),
		.cfg         (cfg),
		.pattern     (pattern_q),
		.step        (step_q),
		.finished    (finished_q),
		.upd         (upd),
		.left_tgt    (left_lut),
		.right_tgt   (right_lut)
	);

	assign left_tgt_n  = upd.load ? left_lut : left_tgt_q;
	assign right_tgt_n = upd.load ? right_lut : right_tgt_q;

	spss_slew #(
		.POS_W   (POS_W),
		.DELTA_W (DELTA_W)
	) u_slew_left (
		.pos      (left_pos_q),
		.tgt      (left_tgt_n),
		.delta    (delta_s1),
		.pos_next (left_slew)
	);

	spss_slew #(
		.POS_W   (POS_W),
		.DELTA_W (DELTA_W)
	) u_slew_right (
		.pos      (right_pos_q),
		.tgt      (right_tgt_n),
		.delta    (delta_s1),
		.pos_next (right_slew)
	);

	assign left_pos_n  = kind_s1 ? left_pos_q : left_slew;
	assign right_pos_n = kind_s1 ? right_pos_q : right_slew;
	assign at_tgt_n    = (left_pos_n == left_tgt_n) && (right_pos_n == right_tgt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_pos_q  <= '0;
			right_pos_q <= '0;
			left_tgt_q  <= POS_W'(spss_pkg::RESET_TARGET_PCT) << POS_FRAC_BITS;
			right_tgt_q <= POS_W'(spss_pkg::RESET_TARGET_PCT) << POS_FRAC_BITS;
			pattern_q   <= '0;
			step_q      <= '0;
			finished_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (valid_s1 && advance) begin
				left_pos_q  <= left_pos_n;
				right_pos_q <= right_pos_n;
				left_tgt_q  <= left_tgt_n;
				right_tgt_q <= right_tgt_n;
				pattern_q   <= upd.pattern;
				step_q      <= upd.step;
				finished_q  <= kind_s1 ? 1'b1 : at_tgt_n;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			left_pulse_q  <= spss_pkg::PULSE_W'(spss_pkg::PULSE_MIN_US)
				+ (spss_pkg::PULSE_W'(to_tenths(left_pos_n)) << 1);
			right_pulse_q <= spss_pkg::PULSE_W'(spss_pkg::PULSE_MAX_US)
				- (spss_pkg::PULSE_W'(to_tenths(right_pos_n)) << 1);
			res_pattern_q <= upd.pattern;
			res_step_q    <= upd.step;
			res_at_tgt_q  <= at_tgt_n;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.left_pulse_us  = left_pulse_q;
	assign res.right_pulse_us = right_pulse_q;
	assign res.active_pattern = res_pattern_q;
	assign res.active_step    = res_step_q;
	assign res.at_target      = res_at_tgt_q;

endmodule
